// ===== hw/rtl/hpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Heater PI duty controller package
// Shared widths, constants, transfer structs and divide-by-constant helpers.
// ----------------------------------------------------------------------------
package hpdc_pkg;

    localparam int SP_W    = 13;
    localparam int TIP_W   = 13;
    localparam int ROOM_W  = 15;
    localparam int DUTY_W  = 10;
    localparam int INTEG_W = 10;
    localparam int ERR_W   = 14;

    // Function codes carried in the input tuser bit.
    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_OFF  = 1'b1;

    // Setpoint limits and reset value, in centidegrees.
    localparam logic [SP_W-1:0] SETPOINT_MIN   = 13'd200;
    localparam logic [SP_W-1:0] SETPOINT_MAX   = 13'd4500;
    localparam logic [SP_W-1:0] SETPOINT_RESET = 13'd3200;

    // Integrator clamp, one bit wider than the integrator for the raw sum.
    localparam logic signed [INTEG_W:0] INTEG_MIN = -11'sd180;
    localparam logic signed [INTEG_W:0] INTEG_MAX = 11'sd420;

    localparam logic signed [16:0]      AMBIENT_MARGIN = 17'sd50;
    localparam logic signed [ERR_W-1:0] READY_BAND     = 14'sd50;
    localparam logic signed [15:0]      HOLD_BOOST     = 16'sd80;
    localparam logic signed [15:0]      DUTY_MAX       = 16'sd1000;

    // Reciprocals for truncating division of non-negative values.
    localparam logic [15:0] RECIP_35 = 16'd29960;  // ceil(2^20 / 35)
    localparam logic [15:0] RECIP_60 = 16'd17477;  // ceil(2^20 / 60)
    localparam logic [15:0] RECIP_3  = 16'd43691;  // ceil(2^17 / 3)

    // One control step as it leaves the input register.
    typedef struct packed {
        logic                     func;
        logic [TIP_W-1:0]         tip_temp;
        logic signed [ROOM_W-1:0] room_temp;
    } step_in_t;

    // One result item.
    typedef struct packed {
        logic [DUTY_W-1:0]         duty_permille;
        logic signed [INTEG_W-1:0] integral_term;
    } step_out_t;

    // Magnitude / 35 for a 14-bit magnitude.
    function automatic logic [7:0] div35(input logic [ERR_W-1:0] x);
        logic [29:0] p;
        begin
            p = 30'(x) * 30'(RECIP_35);
            return p[27:20];
        end
    endfunction

    // Magnitude / 60 for a 14-bit magnitude.
    function automatic logic [7:0] div60(input logic [ERR_W-1:0] x);
        logic [29:0] p;
        begin
            p = 30'(x) * 30'(RECIP_60);
            return p[27:20];
        end
    endfunction

    // Magnitude / 3 for a 15-bit magnitude.
    function automatic logic [12:0] div3(input logic [ERR_W:0] x);
        logic [31:0] p;
        begin
            p = 32'(x) * 32'(RECIP_3);
            return p[29:17];
        end
    endfunction

endpackage

// ===== hw/rtl/hpdc_step.sv =====
// ----------------------------------------------------------------------------
// Heater PI duty controller step logic
// Combinational PI update: error, integrator with clamp, duty with clamp.
// ----------------------------------------------------------------------------
module hpdc_step (
    input  hpdc_pkg::step_in_t                      step_in,
    input  logic [hpdc_pkg::SP_W-1:0]               setpoint,
    input  logic signed [hpdc_pkg::INTEG_W-1:0]     integ_cur,
    output hpdc_pkg::step_out_t                     step_out
);
    import hpdc_pkg::*;

    logic signed [16:0]        room_margin;
    logic                      near_ambient;
    logic signed [ERR_W-1:0]   err;
    logic                      err_neg;
    logic [ERR_W-1:0]          err_mag;
    logic [7:0]                q35;
    logic [7:0]                q60;
    logic signed [INTEG_W:0]   incr;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W:0]   integ_clamp;
    logic [12:0]               q3;
    logic signed [14:0]        p_term;
    logic signed [15:0]        duty_sum;
    logic [DUTY_W-1:0]         duty_sat;

    // Setpoint against ambient plus margin.
    assign room_margin  = 17'(step_in.room_temp) + AMBIENT_MARGIN;
    assign near_ambient = $signed({4'b0, setpoint}) <= room_margin;

    // Error in sign-magnitude form, so every division truncates toward zero.
    assign err     = $signed({1'b0, setpoint}) - $signed({1'b0, step_in.tip_temp});
    assign err_neg = err[ERR_W-1];
    assign err_mag = err_neg ? ERR_W'(-err) : ERR_W'(err);

    // Integrator increment and anti-windup clamp.
    assign q35       = div35(err_mag);
    assign q60       = div60(err_mag);
    assign incr      = err_neg ? -$signed({3'b0, q60}) : $signed({3'b0, q35});
    assign integ_sum = {integ_cur[INTEG_W-1], integ_cur} + incr;

    always_comb
    begin
        priority if (integ_sum < INTEG_MIN)
        begin
            integ_clamp = INTEG_MIN;
        end
        else if (integ_sum > INTEG_MAX)
        begin
            integ_clamp = INTEG_MAX;
        end
        else
        begin
            integ_clamp = integ_sum;
        end
    end

    // Proportional term 2*err/3 plus integrator, with the hold boost.
    assign q3       = div3({err_mag, 1'b0});
    assign p_term   = err_neg ? -$signed({2'b0, q3}) : $signed({2'b0, q3});
    assign duty_sum = 16'(p_term) + 16'(integ_clamp)
                    + ((err > 14'sd0) ? HOLD_BOOST : 16'sd0);

    // Cut-off when far above the setpoint, then saturate.
    always_comb
    begin
        priority if (err < -READY_BAND)
        begin
            duty_sat = '0;
        end
        else if (duty_sum < 16'sd0)
        begin
            duty_sat = '0;
        end
        else if (duty_sum > DUTY_MAX)
        begin
            duty_sat = DUTY_W'(DUTY_MAX);
        end
        else
        begin
            duty_sat = DUTY_W'(duty_sum);
        end
    end

    // Force-off and near-ambient both clear the integrator and the duty.
    always_comb
    begin
        if (step_in.func == FUNC_OFF || near_ambient)
        begin
            step_out.duty_permille = '0;
            step_out.integral_term = '0;
        end
        else
        begin
            step_out.duty_permille = duty_sat;
            step_out.integral_term = INTEG_W'(integ_clamp);
        end
    end

endmodule

// ===== hw/rtl/heater_pi_duty_controller.sv =====
// ----------------------------------------------------------------------------
// Heater PI duty controller
// PI heater duty from tip and ambient temperature, integrator anti-windup.
// ----------------------------------------------------------------------------
// The input register captures each transfer and the result register each step;
// the integrator is updated combinationally between the two registers. One
// item per cycle while the result stream does not stall.
// Reset: asynchronous, active low; clears the valid flags and the
// integrator and loads the setpoint with 3200.
module heater_pi_duty_controller (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: setpoint_cdeg, clamped to 200..4500 on write
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] tip_temp, [27:13] room_temp, rest zero
    input  logic [0:0]  s_tuser,   // [0] func
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [9:0] duty_permille, [19:10] integral_term
);
    import hpdc_pkg::*;

    logic [SP_W-1:0]            setpoint_reg;
    logic [SP_W-1:0]            setpoint_next;
    logic                       in_valid_reg;
    step_in_t                   in_data_reg;
    logic                       out_valid_reg;
    step_out_t                  out_data_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    step_out_t                  step_res;
    logic                       advance;
    logic                       in_xfer;

    // Setpoint saturation on write.
    always_comb
    begin
        priority if (cfg_wdata < SETPOINT_MIN)
        begin
            setpoint_next = SETPOINT_MIN;
        end
        else if (cfg_wdata > SETPOINT_MAX)
        begin
            setpoint_next = SETPOINT_MAX;
        end
        else
        begin
            setpoint_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= SETPOINT_RESET;
        end
        else if (cfg_we)
        begin
            setpoint_reg <= setpoint_next;
        end
    end

    // Pipeline flow: the input stage moves on when the result slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg.func      <= s_tuser[0];
            in_data_reg.tip_temp  <= s_tdata[12:0];
            in_data_reg.room_temp <= $signed(s_tdata[27:13]);
        end
    end

    // Step logic.
    hpdc_step u_step (
        .step_in   (in_data_reg),
        .setpoint  (setpoint_reg),
        .integ_cur (integ_reg),
        .step_out  (step_res)
    );

    // Integrator state follows each completed step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (advance)
        begin
            integ_reg <= step_res.integral_term;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg.integral_term, out_data_reg.duty_permille};

`ifndef SYNTHESIS
    // The integrator never leaves its clamp range.
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg >= -10'sd180) && (integ_reg <= 10'sd420))
        else $error("integrator out of range");

    // The setpoint register always holds a clamped value.
    a_setpoint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (setpoint_reg >= SETPOINT_MIN) && (setpoint_reg <= SETPOINT_MAX))
        else $error("setpoint out of range");

    // A force-off step leaves the integrator cleared.
    a_force_off: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_data_reg.func == FUNC_OFF) |=> integ_reg == '0)
        else $error("force off did not clear integrator");

    // A pending result reports the current integrator state.
    a_integ_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.integral_term == integ_reg)
        else $error("result integrator differs from state");
`endif

endmodule

// ===== bench/heater_pi_duty_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Heater PI duty controller testbench
// Sends control steps through the input stream and checks every result
// against a cycle-free model of the PI law, its integrator clamp and the
// ambient cutoff, or typed values. A directed table runs first, then random
// phases, each after a setpoint write. Both streams stall at random.
// ----------------------------------------------------------------------------
module heater_pi_duty_controller_tb;

    import hpdc_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 241;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 400;
    localparam int RISE_DIVISOR  = 35;
    localparam int FALL_DIVISOR  = 60;
    localparam int MAX_REPORTS   = 10;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_ITEM,   // checked against the model
        ROW_FIXED,  // checked against the values typed in the row
        ROW_CFG     // setpoint write once the block is idle
    } row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [SP_W-1:0]   cfg_val;
        logic              func;
        logic [TIP_W-1:0]  tip;
        logic [ROOM_W-1:0] room;
        logic [DUTY_W-1:0] duty;
        logic [INTEG_W-1:0] integ;
    } dir_row_t;

    localparam int DIR_ROWS_N = 23;
    localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
        // Force off right after reset.
        '{ROW_FIXED, 13'd0, FUNC_OFF, 13'd0, 15'd0, 10'd0, 10'd0},
        // Ambient at its maximum, far above the setpoint.
        '{ROW_FIXED, 13'd0, FUNC_STEP, 13'd0, 15'h3FFF, 10'd0, 10'd0},
        // Setpoint exactly 50 above ambient still cuts off.
        '{ROW_FIXED, 13'd0, FUNC_STEP, 13'd3200, 15'd3150, 10'd0, 10'd0},
        // One above the cutoff, zero error.
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd3200, 15'd3149, 10'd0, 10'd0},
        // Coldest tip and coldest ambient: full duty.
        '{ROW_FIXED, 13'd0, FUNC_STEP, 13'd0, 15'h4000, 10'd1000, 10'd91},
        // Wind the integrator up into its upper clamp.
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd0, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd0, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd0, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd0, 15'd0, 10'd0, 10'd0},
        // Small overshoot, edge of the ready band, just past it.
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd3201, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd3250, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd3251, 15'd0, 10'd0, 10'd0},
        // Hottest tip.
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd8191, 15'd0, 10'd0, 10'd0},
        // Setpoint written as zero saturates to the minimum.
        '{ROW_CFG, 13'd0, FUNC_STEP, 13'd0, 15'd0, 10'd0, 10'd0},
        // Largest negative error drives the integrator to its lower clamp.
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd8191, 15'h4000, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd8191, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd8191, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd8191, 15'd0, 10'd0, 10'd0},
        // Positive error with a negative integrator: duty floors at zero.
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd199, 15'd149, 10'd0, 10'd0},
        // Force off with every other field at its maximum.
        '{ROW_FIXED, 13'd0, FUNC_OFF, 13'd8191, 15'h3FFF, 10'd0, 10'd0},
        // Setpoint written as all ones saturates to the maximum.
        '{ROW_CFG, 13'd8191, FUNC_STEP, 13'd0, 15'd0, 10'd0, 10'd0},
        '{ROW_ITEM, 13'd0, FUNC_STEP, 13'd0, 15'd4449, 10'd0, 10'd0},
        '{ROW_FIXED, 13'd0, FUNC_STEP, 13'd4500, 15'd4450, 10'd0, 10'd0}
    };

    // Setpoints for the random phases; the last phases pick their own.
    localparam int SWEEP_N = 6;
    localparam logic [SP_W-1:0] SP_SWEEP [0:SWEEP_N-1] = '{
        13'd0, 13'd8191, 13'd199, 13'd4501, 13'd200, 13'd4500
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [12:0] tip_temp, [27:13] room_temp, rest zero
    logic [0:0]  s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [9:0] duty_permille, [19:10] integral_term

    // Controller state as the checker sees it.
    int setpoint_cdeg;
    int integ_acc;

    step_out_t pending_duty_q[$];
    int        mismatch_count = 0;
    int        result_count   = 0;
    int        cycle_count    = 0;
    bit        long_hold_done = 1'b0;

    heater_pi_duty_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // One control step of the PI law, updating the integrator copy.
    function automatic step_out_t compute_duty(input logic func,
                                               input logic [TIP_W-1:0] tip,
                                               input logic signed [ROOM_W-1:0] room);
        int        err;
        int        duty;
        step_out_t res;
        res = '0;
        if (func == FUNC_OFF || setpoint_cdeg <= int'(room) + int'(AMBIENT_MARGIN))
        begin
            integ_acc = 0;
            return res;
        end
        err = setpoint_cdeg - int'(tip);
        if (err >= 0)
            integ_acc += err / RISE_DIVISOR;
        else
            integ_acc += err / FALL_DIVISOR;
        if (integ_acc < int'(INTEG_MIN))
            integ_acc = int'(INTEG_MIN);
        if (integ_acc > int'(INTEG_MAX))
            integ_acc = int'(INTEG_MAX);

        duty = (err * 2) / 3 + integ_acc;
        if (err > 0)
            duty += int'(HOLD_BOOST);
        if (err < -int'(READY_BAND))
            duty = 0;
        if (duty < 0)
            duty = 0;
        if (duty > int'(DUTY_MAX))
            duty = int'(DUTY_MAX);

        res.duty_permille = 10'(duty);
        res.integral_term = 10'(integ_acc);
        return res;
    endfunction

    // Offer one step and record its expected result once it is taken.
    task automatic send_step(input logic func, input logic [TIP_W-1:0] tip,
                             input logic [ROOM_W-1:0] room, input bit fixed,
                             input step_out_t fixed_res);
        step_out_t res;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, room, tip};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = compute_duty(func, tip, room);
        if (fixed)
            res = fixed_res;
        pending_duty_q.push_back(res);
    endtask

    // Random idle stretch on the input side, mostly short.
    task automatic source_gap();
        int len;
        if ($urandom_range(0, 99) < 25)
        begin
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(20, 60);
            else
                len = $urandom_range(1, 3);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (len - 1) @(negedge clk);
        end
    endtask

    // Stop sending, let every result come back, then write the setpoint.
    task automatic drain_and_configure(input logic [SP_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_duty_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        if (value < SETPOINT_MIN)
            setpoint_cdeg = int'(SETPOINT_MIN);
        else if (value > SETPOINT_MAX)
            setpoint_cdeg = int'(SETPOINT_MAX);
        else
            setpoint_cdeg = int'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        logic                     func;
        logic [TIP_W-1:0]         tip;
        logic signed [ROOM_W-1:0] room;
        logic [SP_W-1:0]          sp_val;
        bit                       gaps;
        int                       v;
        int                       pick;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        setpoint_cdeg = int'(SETPOINT_RESET);
        integ_acc     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS_N; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                drain_and_configure(DIR_ROWS[i].cfg_val);
            else
            begin
                source_gap();
                send_step(DIR_ROWS[i].func, DIR_ROWS[i].tip, DIR_ROWS[i].room,
                          DIR_ROWS[i].kind == ROW_FIXED,
                          step_out_t'({DIR_ROWS[i].duty, DIR_ROWS[i].integ}));
            end
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph < SWEEP_N)
                sp_val = SP_SWEEP[ph];
            else
                sp_val = 13'($urandom_range(0, 8191));
            drain_and_configure(sp_val);
            // Every other phase runs without input gaps.
            gaps = ph[0];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                func = ($urandom_range(0, 99) < 5) ? FUNC_OFF : FUNC_STEP;

                // Tip mostly around the setpoint so the integrator moves.
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    v = setpoint_cdeg + int'($urandom_range(0, 400)) - 200;
                    if (v < 0)
                        v = 0;
                    tip = 13'(v);
                end
                else if (pick < 90)
                    tip = 13'($urandom_range(0, 8191));
                else
                    tip = $urandom_range(0, 1) ? 13'd8191 : 13'd0;

                // Ambient mostly cold enough to let the loop run.
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    v = setpoint_cdeg - 51 - int'($urandom_range(0, 3000));
                    room = 15'(v);
                end
                else if (pick < 85)
                    room = 15'(setpoint_cdeg - 52 + int'($urandom_range(0, 4)));
                else
                    room = 15'($urandom_range(0, 32767));

                if (gaps)
                    source_gap();
                send_step(func, tip, room, 1'b0, '0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_duty_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Output side: random stalls, quiet stretches and one long hold-off.
    initial
    begin
        int len;
        int pick;
        int quiet_left;
        quiet_left = 0;
        m_tready   = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            len  = 1;
            pick = $urandom_range(0, 99);
            if (!long_hold_done && result_count >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                len = HOLD_CYCLES;
            end
            else if (quiet_left > 0)
            begin
                m_tready <= 1'b1;
                quiet_left--;
            end
            else if (pick < 3)
            begin
                m_tready <= 1'b1;
                quiet_left = 200;
            end
            else if (pick < 6)
            begin
                m_tready <= 1'b0;
                len = $urandom_range(20, 60);
            end
            else if (pick < 30)
            begin
                m_tready <= 1'b0;
                len = $urandom_range(1, 3);
            end
            else
                m_tready <= 1'b1;
            repeat (len) @(negedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        step_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count <= result_count + 1;
            if (pending_duty_q.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: duty %0d integral %0d",
                             m_tdata[9:0], $signed(m_tdata[19:10]));
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                want = pending_duty_q.pop_front();
                if (m_tdata[9:0] !== want.duty_permille
                    || m_tdata[19:10] !== want.integral_term)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("result %0d: duty exp %0d got %0d, integral exp %0d got %0d",
                                 result_count, want.duty_permille, m_tdata[9:0],
                                 want.integral_term, $signed(m_tdata[19:10]));
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
